### design/rpn_pkg.sv
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DATA_W      = 32;

	// word modes
	localparam logic [2:0] MODE_PUSH   = 3'd0;
	localparam logic [2:0] MODE_UNARY  = 3'd1;
	localparam logic [2:0] MODE_BINARY = 3'd2;
	localparam logic [2:0] MODE_SHORT  = 3'd3;
	localparam logic [2:0] MODE_MARK   = 3'd4;
	localparam logic [2:0] MODE_FINISH = 3'd5;

	// unary ops
	localparam logic [3:0] UOP_BITNOT = 4'd0;
	localparam logic [3:0] UOP_NOT    = 4'd1;

	// binary ops
	localparam logic [3:0] BOP_LT  = 4'd0;
	localparam logic [3:0] BOP_LE  = 4'd1;
	localparam logic [3:0] BOP_GT  = 4'd2;
	localparam logic [3:0] BOP_GE  = 4'd3;
	localparam logic [3:0] BOP_EQ  = 4'd4;
	localparam logic [3:0] BOP_NE  = 4'd5;
	localparam logic [3:0] BOP_AND = 4'd6;
	localparam logic [3:0] BOP_OR  = 4'd7;
	localparam logic [3:0] BOP_XOR = 4'd8;

	// short-circuit ops
	localparam logic [3:0] SOP_AND = 4'd0;
	localparam logic [3:0] SOP_OR  = 4'd1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_BADOP = 2'd3;

	typedef struct packed {
		logic [2:0]               mode;
		logic [3:0]               op;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result;
		logic [1:0]               status;
	} out_t;

	// stack memory request, issued every cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// a is the left operand (pushed first)
	function automatic logic [DATA_W-1:0] binop(input logic [3:0] op,
		input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] r;
		r = '0;
		unique case (op)
			BOP_LT:  r = {{(DATA_W-1){1'b0}}, ($signed(a) <  $signed(b))};
			BOP_LE:  r = {{(DATA_W-1){1'b0}}, ($signed(a) <= $signed(b))};
			BOP_GT:  r = {{(DATA_W-1){1'b0}}, ($signed(a) >  $signed(b))};
			BOP_GE:  r = {{(DATA_W-1){1'b0}}, ($signed(a) >= $signed(b))};
			BOP_EQ:  r = {{(DATA_W-1){1'b0}}, (a == b)};
			BOP_NE:  r = {{(DATA_W-1){1'b0}}, (a != b)};
			BOP_AND: r = a & b;
			BOP_OR:  r = a | b;
			default: r = a ^ b;
		endcase
		return r;
	endfunction

endpackage

### design/rpn_ram.sv
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/rpn_core.sv
module rpn_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              rdy,
	input  rpn_pkg::in_t      in_data,
	output rpn_pkg::ram_req_t ram_req,
	input  logic [31:0]       ram_rdata,
	output logic              fin_valid,
	output rpn_pkg::out_t     fin_data
);

	localparam logic [rpn_pkg::CNT_W-1:0] FULL = rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH);

	logic [rpn_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic [31:0]               tos_q, tos_n, nos_q, nos_n;
	logic                      skip_q, skip_n, seen_q, seen_n;
	logic [7:0]                nest_q, nest_n;
	logic [1:0]                err_q, err_n;
	logic                      byp_q;
	logic [31:0]               byp_data_q;
	logic [31:0]               third;
	logic                      in_fire;
	logic [rpn_pkg::CNT_W-1:0] wa_full, ra_full;

	assign in_fire = in_valid & rdy;
	// entry three down: bypassed when it was written the cycle before
	assign third   = byp_q ? byp_data_q : ram_rdata;

	always_comb begin
		cnt_n         = cnt_q;
		tos_n         = tos_q;
		nos_n         = nos_q;
		skip_n        = skip_q;
		nest_n        = nest_q;
		err_n         = err_q;
		seen_n        = seen_q;
		ram_req.we    = 1'b0;
		wa_full       = cnt_q - rpn_pkg::CNT_W'(2);
		ram_req.waddr = wa_full[rpn_pkg::ADDR_W-1:0];
		ram_req.wdata = nos_q;
		fin_valid     = 1'b0;
		fin_data      = '0;
		if (in_fire) begin
			if (in_data.mode == rpn_pkg::MODE_FINISH) begin
				fin_valid = 1'b1;
				if (err_q != rpn_pkg::ST_OK) begin
					fin_data.status = err_q;
				end else if (!seen_q) begin
					fin_data.result = 32'sd1;
				end else if (cnt_q == '0) begin
					fin_data.status = rpn_pkg::ST_UNDER;
				end else begin
					fin_data.result = $signed(tos_q);
				end
				cnt_n  = '0;
				skip_n = 1'b0;
				nest_n = '0;
				err_n  = rpn_pkg::ST_OK;
				seen_n = 1'b0;
			end else begin
				seen_n = 1'b1;
				if (err_q != rpn_pkg::ST_OK) begin
					// latched error: ignore
				end else if (skip_q) begin
					if (in_data.mode == rpn_pkg::MODE_SHORT) begin
						if (nest_q != 8'hFF) nest_n = nest_q + 8'd1;
					end else if (in_data.mode == rpn_pkg::MODE_MARK) begin
						if (nest_q == '0) skip_n = 1'b0;
						else nest_n = nest_q - 8'd1;
					end
				end else begin
					unique case (in_data.mode)
						rpn_pkg::MODE_PUSH: begin
							if (cnt_q == FULL) begin
								err_n = rpn_pkg::ST_OVER;
							end else begin
								// spill nos to the memory
								ram_req.we = (cnt_q >= rpn_pkg::CNT_W'(2));
								cnt_n      = cnt_q + rpn_pkg::CNT_W'(1);
								nos_n      = tos_q;
								tos_n      = in_data.value;
							end
						end
						rpn_pkg::MODE_UNARY: begin
							if (in_data.op > rpn_pkg::UOP_NOT) begin
								err_n = rpn_pkg::ST_BADOP;
							end else if (cnt_q == '0) begin
								err_n = rpn_pkg::ST_UNDER;
							end else if (in_data.op == rpn_pkg::UOP_BITNOT) begin
								tos_n = ~tos_q;
							end else begin
								tos_n = {31'b0, (tos_q == '0)};
							end
						end
						rpn_pkg::MODE_BINARY: begin
							if (in_data.op > rpn_pkg::BOP_XOR) begin
								err_n = rpn_pkg::ST_BADOP;
							end else if (cnt_q < rpn_pkg::CNT_W'(2)) begin
								err_n = rpn_pkg::ST_UNDER;
							end else begin
								cnt_n = cnt_q - rpn_pkg::CNT_W'(1);
								tos_n = rpn_pkg::binop(in_data.op, nos_q, tos_q);
								nos_n = third;
							end
						end
						rpn_pkg::MODE_SHORT: begin
							if (in_data.op > rpn_pkg::SOP_OR) begin
								err_n = rpn_pkg::ST_BADOP;
							end else if (cnt_q == '0) begin
								err_n = rpn_pkg::ST_UNDER;
							end else if ((in_data.op == rpn_pkg::SOP_AND) ==
								(tos_q == '0)) begin
								// operand decides: keep it, skip to marker
								skip_n = 1'b1;
								nest_n = '0;
							end else begin
								cnt_n = cnt_q - rpn_pkg::CNT_W'(1);
								tos_n = nos_q;
								nos_n = third;
							end
						end
						rpn_pkg::MODE_MARK: begin
						end
						default: begin
							err_n = rpn_pkg::ST_BADOP;
						end
					endcase
				end
			end
		end
		// prefetch the entry below the new nos
		ra_full = cnt_n - rpn_pkg::CNT_W'(3);
		if (cnt_n >= rpn_pkg::CNT_W'(3)) ram_req.raddr = ra_full[rpn_pkg::ADDR_W-1:0];
		else ram_req.raddr = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			skip_q <= 1'b0;
			nest_q <= '0;
			err_q  <= rpn_pkg::ST_OK;
			seen_q <= 1'b0;
			byp_q  <= 1'b0;
		end else begin
			cnt_q  <= cnt_n;
			skip_q <= skip_n;
			nest_q <= nest_n;
			err_q  <= err_n;
			seen_q <= seen_n;
			byp_q  <= ram_req.we && (ram_req.waddr == ram_req.raddr);
		end
	end

	always_ff @(posedge clk) begin
		tos_q      <= tos_n;
		nos_q      <= nos_n;
		byp_data_q <= ram_req.wdata;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("stack count beyond depth");

	a_byp_src: assert property (@(posedge clk) disable iff (!arst_n)
		byp_q |-> $past(ram_req.we))
		else $error("bypass without a preceding spill");

	a_nest_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(nest_q != '0) |-> skip_q)
		else $error("skip nesting outside a skip");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != rpn_pkg::ST_OK && !(in_fire && in_data.mode == rpn_pkg::MODE_FINISH))
		|=> err_q == $past(err_q))
		else $error("latched error changed before finish");

endmodule

### design/rpn_outbuf.sv
module rpn_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fin_valid,
	input  rpn_pkg::out_t fin_data,
	output logic          rdy,
	output logic          out_valid,
	input  logic          out_ready,
	output rpn_pkg::out_t out_data
);

	logic          out_valid_q, sk_valid_q;
	rpn_pkg::out_t out_q, sk_q;
	logic          free;

	assign rdy       = !sk_valid_q;
	assign free      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (free) begin
			if (sk_valid_q) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= fin_valid;
			end else begin
				out_valid_q <= fin_valid;
			end
		end else if (fin_valid) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (sk_valid_q) begin
				out_q <= sk_q;
				if (fin_valid) sk_q <= fin_data;
			end else if (fin_valid) begin
				out_q <= fin_data;
			end
		end else if (fin_valid) begin
			sk_q <= fin_data;
		end
	end

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> out_valid_q)
		else $error("skid stage full while output empty");

endmodule

### design/rpn_stack_evaluator.sv
// A finish request's result is registered in the output register or else in the skid stage.
// One code word per cycle unless in_ready drops; top and second of stack sit in registers and
// the entry below is prefetched from the single-port-read stack memory, with a bypass after a
// spill. in_ready drops only while both the output register and the skid stage hold results.
// Reset clears stack count, skip state, error and output valids; stack memory is not cleared.
module rpn_stack_evaluator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rpn_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rpn_pkg::out_t out_data
);

	// memory request from the core; issued every cycle
	rpn_pkg::ram_req_t ram_req;
	logic [31:0]       ram_rdata;

	// finish result handed to the output buffer
	logic              fin_valid;
	rpn_pkg::out_t     fin_data;

	// Stack layout: entries 0 .. count-3 live in memory, the top two in core registers.
	// A push spills the old second entry; a pop refills it from the prefetched read.
	rpn_ram #(
		.WIDTH (rpn_pkg::DATA_W),
		.DEPTH (rpn_pkg::STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// Decode and execute: skip tracking, error latch, compare/logic unit
	rpn_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.rdy       (in_ready),
		.in_data   (in_data),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.fin_valid (fin_valid),
		.fin_data  (fin_data)
	);

	// Output register plus skid stage, so words keep flowing while a result waits
	rpn_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_data  (fin_data),
		.rdy       (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpn_pkg::*;

	// modes outside the defined set, both rejected as bad ops
	localparam logic [2:0] MODE_BAD6 = 3'd6;
	localparam logic [2:0] MODE_BAD7 = 3'd7;

	localparam int OP_CODES     = 16;      // every code the 4-bit op field can carry
	localparam int NEST_MAX     = 255;     // skip nesting saturates here
	localparam int RANDOM_WORDS = 420;     // code words that take effect in the random phase
	localparam int DRAIN_TAIL   = 4;       // output register plus the skid stage, with margin
	localparam int CYCLE_LIMIT  = 300_000;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	in_t   in_data;
	logic  out_valid;
	logic  out_ready;
	out_t  out_data;

	rpn_stack_evaluator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// ------------------------------------------------------------------
	// Shadow of the evaluator: value stack, depth, skip state, latched
	// error and the "word seen" flag, updated once per accepted request.
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
	int                shadow_depth;
	bit                shadow_skip;
	int                shadow_nest;
	logic [1:0]        shadow_err;
	bit                shadow_seen;

	out_t        finish_results_q[$];  // results owed by accepted finish requests, oldest first
	int          status_hist [4];
	int          mismatches;
	int          words_accepted;
	int          words_effective;
	int          results_seen;
	bit          steady;               // set: neither side idles
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			finish_results_q.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	function automatic in_t code_word(int mode, int op, int value);
		in_t w;
		w.mode  = mode[2:0];
		w.op    = op[3:0];
		w.value = value;
		return w;
	endfunction

	// Push onto the shadow stack; a full stack latches overflow instead.
	function automatic void shadow_push(logic [DATA_W-1:0] v);
		if (shadow_depth >= STACK_DEPTH) begin
			if (shadow_err == ST_OK)
				shadow_err = ST_OVER;
		end else begin
			shadow_stack[shadow_depth] = v;
			shadow_depth++;
		end
	endfunction

	function automatic void shadow_latch(logic [1:0] code);
		if (shadow_err == ST_OK)
			shadow_err = code;
	endfunction

	// Advance the shadow by one code word. A finish queues the result it owes.
	// Returns 0 for words the block merely ignores (after an error, or
	// anything but short-circuit and marker words while skipping).
	function automatic bit evaluate_word(in_t w);
		logic [DATA_W-1:0] a, b, t;
		out_t              r;
		bit                decides;
		if (w.mode == MODE_FINISH) begin
			r.result = '0;
			r.status = ST_OK;
			if (shadow_err != ST_OK)
				r.status = shadow_err;
			else if (!shadow_seen)
				r.result = 1;           // empty expression counts as true
			else if (shadow_depth == 0)
				r.status = ST_UNDER;
			else
				r.result = shadow_stack[shadow_depth-1];
			finish_results_q.push_back(r);
			status_hist[r.status]++;
			shadow_depth = 0;
			shadow_skip  = 1'b0;
			shadow_nest  = 0;
			shadow_err   = ST_OK;
			shadow_seen  = 1'b0;
			return 1'b1;
		end
		shadow_seen = 1'b1;
		if (shadow_err != ST_OK)
			return 1'b0;
		if (shadow_skip) begin
			// only nesting is tracked; any op of a short-circuit word counts
			if (w.mode == MODE_SHORT) begin
				if (shadow_nest < NEST_MAX)
					shadow_nest++;
				return 1'b1;
			end
			if (w.mode == MODE_MARK) begin
				if (shadow_nest == 0)
					shadow_skip = 1'b0;
				else
					shadow_nest--;
				return 1'b1;
			end
			return 1'b0;
		end
		case (w.mode)
			MODE_PUSH: shadow_push(w.value);
			MODE_UNARY: begin
				if (w.op > UOP_NOT)
					shadow_latch(ST_BADOP);
				else if (shadow_depth == 0)
					shadow_latch(ST_UNDER);
				else begin
					t = shadow_stack[shadow_depth-1];
					shadow_stack[shadow_depth-1] = (w.op == UOP_BITNOT) ? ~t :
						((t == '0) ? DATA_W'(1) : '0);
				end
			end
			MODE_BINARY: begin
				if (w.op > BOP_XOR)
					shadow_latch(ST_BADOP);
				else if (shadow_depth < 2)
					shadow_latch(ST_UNDER);
				else begin
					b = shadow_stack[shadow_depth-1];
					a = shadow_stack[shadow_depth-2];  // left operand, pushed first
					shadow_depth -= 2;
					case (w.op)
						BOP_LT:  t = ($signed(a) <  $signed(b)) ? DATA_W'(1) : '0;
						BOP_LE:  t = ($signed(a) <= $signed(b)) ? DATA_W'(1) : '0;
						BOP_GT:  t = ($signed(a) >  $signed(b)) ? DATA_W'(1) : '0;
						BOP_GE:  t = ($signed(a) >= $signed(b)) ? DATA_W'(1) : '0;
						BOP_EQ:  t = (a == b) ? DATA_W'(1) : '0;
						BOP_NE:  t = (a != b) ? DATA_W'(1) : '0;
						BOP_AND: t = a & b;
						BOP_OR:  t = a | b;
						default: t = a ^ b;
					endcase
					shadow_push(t);
				end
			end
			MODE_SHORT: begin
				if (w.op > SOP_OR)
					shadow_latch(ST_BADOP);
				else if (shadow_depth == 0)
					shadow_latch(ST_UNDER);
				else begin
					t = shadow_stack[shadow_depth-1];
					decides = (w.op == SOP_AND) ? (t == '0) : (t != '0);
					if (decides) begin
						// left operand stays as the value; skip to the matching marker
						shadow_skip = 1'b1;
						shadow_nest = 0;
					end else
						shadow_depth--;
				end
			end
			MODE_MARK: ;
			default: shadow_latch(ST_BADOP);
		endcase
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Request side. Valid is raised after a random gap and held with the
	// word until the handshake; the shadow is advanced on acceptance.
	// Valid is left high on return, so the caller either sends again or
	// drains in the same time step.
	// ------------------------------------------------------------------
	task automatic send_word(input in_t w);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		words_accepted++;
		if (evaluate_word(w))
			words_effective++;
	endtask

	// non-push words carry junk in value so its bits keep toggling
	task automatic send_op(input int mode, input int op);
		send_word(code_word(mode, op, $urandom));
	endtask

	task automatic send_push(input int v);
		send_word(code_word(MODE_PUSH, $urandom_range(0, OP_CODES - 1), v));
	endtask

	task automatic send_marker;
		send_op(MODE_MARK, $urandom_range(0, OP_CODES - 1));
	endtask

	task automatic send_finish;
		send_op(MODE_FINISH, $urandom_range(0, OP_CODES - 1));
	endtask

	// Sender holds off until every owed result has been taken, then lets
	// the pipeline settle.
	task automatic wait_results_drained;
		in_valid <= 1'b0;
		while (finish_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: compare each taken result with the oldest owed one and
	// stall out_ready at random after every result, except while steady.
	// ------------------------------------------------------------------
	initial begin : result_checker
		int   stall;
		out_t want;
		out_ready <= 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (finish_results_q.size() == 0)
					report_mismatch($sformatf("result %0d status %0d with no finish pending",
						out_data.result, out_data.status));
				else begin
					want = finish_results_q.pop_front();
					if (out_data.result !== want.result)
						report_mismatch($sformatf("result %0d, expected %0d",
							out_data.result, want.result));
					if (out_data.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							out_data.status, want.status));
				end
				stall = steady ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic int pick_value();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return -1;
			3: return 32'h8000_0000;
			4: return 32'h7fff_ffff;
			5: return int'($urandom_range(0, 9)) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t noise_word();
		return code_word($urandom_range(0, 7), $urandom_range(0, OP_CODES - 1), $urandom);
	endfunction

	// Well-formed random expression. avail counts operands the expression
	// has on the stack; open_base holds, per open short-circuit, the depth
	// once its left operand is popped, so its right side must end one above.
	function automatic void build_expression(ref in_t words[$]);
		int open_base[$];
		int avail;
		int floor_lvl;
		avail = 0;
		repeat ($urandom_range(1, 14)) begin
			floor_lvl = (open_base.size() != 0) ? open_base[$] : 0;
			case ($urandom_range(0, 5))
				0, 1: if (avail < 7) begin
					words.push_back(code_word(MODE_PUSH, $urandom_range(0, OP_CODES - 1),
						pick_value()));
					avail++;
				end
				2: if (avail > floor_lvl)
					words.push_back(code_word(MODE_UNARY,
						$urandom_range(UOP_BITNOT, UOP_NOT), $urandom));
				3: if (avail >= floor_lvl + 2) begin
					words.push_back(code_word(MODE_BINARY,
						$urandom_range(BOP_LT, BOP_XOR), $urandom));
					avail--;
				end
				4: if (avail > floor_lvl) begin
					words.push_back(code_word(MODE_SHORT,
						$urandom_range(SOP_AND, SOP_OR), $urandom));
					avail--;
					open_base.push_back(avail);
				end
				default: if (open_base.size() != 0 && avail == floor_lvl + 1) begin
					words.push_back(code_word(MODE_MARK, 0, $urandom));
					void'(open_base.pop_back());
				end
			endcase
		end
		// close whatever is still open, innermost first
		while (open_base.size() != 0) begin
			floor_lvl = open_base[$];
			if (avail == floor_lvl) begin
				words.push_back(code_word(MODE_PUSH, 0, pick_value()));
				avail++;
			end
			while (avail > floor_lvl + 1) begin
				words.push_back(code_word(MODE_BINARY, $urandom_range(BOP_LT, BOP_XOR),
					$urandom));
				avail--;
			end
			words.push_back(code_word(MODE_MARK, 0, $urandom));
			void'(open_base.pop_back());
		end
		if (avail == 0) begin
			words.push_back(code_word(MODE_PUSH, 0, pick_value()));
			avail++;
		end
		while (avail > 1) begin
			words.push_back(code_word(MODE_BINARY, $urandom_range(BOP_LT, BOP_XOR), $urandom));
			avail--;
		end
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every unary and binary operation in one chain, fed with the extremes
	// of the value range.
	task automatic test_operator_chain;
		send_push(32'h8000_0000);
		send_push(32'h7fff_ffff);
		send_op(MODE_BINARY, BOP_LT);
		send_push(-1);
		send_op(MODE_BINARY, BOP_LE);
		send_push(0);
		send_op(MODE_BINARY, BOP_GT);
		send_push(0);
		send_op(MODE_BINARY, BOP_GE);
		send_push(1);
		send_op(MODE_BINARY, BOP_EQ);
		send_push(5);
		send_op(MODE_BINARY, BOP_NE);
		send_push(-1);
		send_op(MODE_BINARY, BOP_AND);
		send_push(32'h8000_0000);
		send_op(MODE_BINARY, BOP_OR);
		send_push(32'h7fff_ffff);
		send_op(MODE_BINARY, BOP_XOR);
		send_op(MODE_UNARY, UOP_BITNOT);
		send_op(MODE_UNARY, UOP_NOT);
		send_finish;
	endtask

	task automatic test_short_circuit;
		// zero decides an and; a nested or inside the skipped part
		send_push(0);
		send_op(MODE_SHORT, SOP_AND);
		send_push(5);
		send_op(MODE_SHORT, SOP_OR);
		send_push(7);
		send_marker;
		send_marker;
		send_finish;
		// non-zero decides an or, then the kept operand is used again
		send_push(3);
		send_op(MODE_SHORT, SOP_OR);
		send_push(9);
		send_marker;
		send_push(4);
		send_op(MODE_BINARY, BOP_AND);
		send_finish;
		// neither decides: right side becomes the value
		send_push(2);
		send_op(MODE_SHORT, SOP_AND);
		send_push(6);
		send_marker;
		send_finish;
		send_push(0);
		send_op(MODE_SHORT, SOP_OR);
		send_push(-1);
		send_marker;
		send_finish;
		// marker outside a skip is a no-op
		send_marker;
		send_push(8);
		send_marker;
		send_finish;
		// finish in the middle of a skip
		send_push(0);
		send_op(MODE_SHORT, SOP_AND);
		send_push(1);
		send_finish;
		// empty expression
		send_finish;
		// bad modes and ops are harmless while skipping; a bad short op still nests
		send_push(1);
		send_op(MODE_SHORT, SOP_OR);
		send_op(MODE_BAD6, 0);
		send_op(MODE_BAD7, 0);
		send_op(MODE_BINARY, OP_CODES - 1);
		send_op(MODE_SHORT, OP_CODES - 1);
		send_marker;
		send_marker;
		send_push(2);
		send_finish;
	endtask

	task automatic test_stack_errors;
		// underflow on each kind of pop, later words ignored
		send_push(1);
		send_op(MODE_BINARY, BOP_LT);
		send_push(2);
		send_finish;
		send_op(MODE_UNARY, UOP_NOT);
		send_finish;
		send_op(MODE_SHORT, SOP_AND);
		send_finish;
		// finish on an empty stack after a word
		send_marker;
		send_finish;
		// bad op codes for every op-carrying mode
		for (int o = UOP_NOT + 1; o < OP_CODES; o++) begin
			send_push($urandom);
			send_op(MODE_UNARY, o);
			send_finish;
		end
		for (int o = BOP_XOR + 1; o < OP_CODES; o++) begin
			send_push($urandom);
			send_push($urandom);
			send_op(MODE_BINARY, o);
			send_finish;
		end
		for (int o = SOP_OR + 1; o < OP_CODES; o++) begin
			send_push($urandom);
			send_op(MODE_SHORT, o);
			send_finish;
		end
		send_push(1);
		send_op(MODE_BAD6, $urandom_range(0, OP_CODES - 1));
		send_finish;
		send_push(1);
		send_op(MODE_BAD7, $urandom_range(0, OP_CODES - 1));
		send_finish;
		// the first error is the one reported
		send_op(MODE_UNARY, UOP_BITNOT);
		send_op(MODE_BAD7, 0);
		send_push(3);
		send_finish;
		// full stack is fine, one more overflows
		repeat (STACK_DEPTH) send_push(pick_value());
		send_finish;
		repeat (STACK_DEPTH + 1) send_push(pick_value());
		send_op(MODE_BINARY, BOP_OR);
		send_finish;
	endtask

	// More nested short-circuit words than the counter holds: it sticks at
	// its ceiling, so NEST_MAX + 1 markers end the skip whatever came before.
	task automatic test_nesting_saturation;
		send_push(pick_value() | 1);
		send_op(MODE_SHORT, SOP_OR);
		repeat (NEST_MAX + 45) send_op(MODE_SHORT, $urandom_range(0, OP_CODES - 1));
		repeat (NEST_MAX + 1) send_marker;
		send_push($urandom);
		send_finish;
	endtask

	// Mostly well-formed expressions with random content; the rest are cut
	// short or salted with junk, pure noise, empty, or so deep that some overflow.
	task automatic test_random_expressions;
		in_t words[$];
		int  start;
		int  pick;
		start = words_effective;
		while (words_effective - start < RANDOM_WORDS) begin
			words.delete();
			if ($urandom_range(0, 5) == 0)
				steady = !steady;
			pick = $urandom_range(0, 99);
			if (pick < 78)
				build_expression(words);
			else if (pick < 86) begin
				build_expression(words);
				if ($urandom_range(0, 1) == 0)
					words = words[0:$urandom_range(0, words.size() - 1)];
				else
					words.insert($urandom_range(0, words.size()), noise_word());
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 6)) words.push_back(noise_word());
			end else if (pick < 97) begin
				// leave empty
			end else begin
				repeat ($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2))
					words.push_back(code_word(MODE_PUSH, 0, pick_value()));
			end
			foreach (words[i])
				send_word(words[i]);
			send_finish;
			if ($urandom_range(0, 39) == 0)
				wait_results_drained;
		end
		steady = 1'b0;
	endtask

	initial begin : main
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		steady       = 1'b0;
		shadow_depth = 0;
		shadow_skip  = 1'b0;
		shadow_nest  = 0;
		shadow_err   = ST_OK;
		shadow_seen  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_operator_chain;
		wait_results_drained;
		test_short_circuit;
		wait_results_drained;
		test_stack_errors;
		wait_results_drained;
		test_nesting_saturation;
		wait_results_drained;
		test_random_expressions;
		wait_results_drained;

		$display("covered %0d code words (%0d not ignored), %0d results checked in %0d cycles",
			words_accepted, words_effective, results_seen, cycles);
		$display("finish outcomes: %0d ok, %0d underflow, %0d overflow, %0d bad op",
			status_hist[ST_OK], status_hist[ST_UNDER], status_hist[ST_OVER],
			status_hist[ST_BADOP]);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
